// ===== rtl/core/ftgs_pkg.sv =====
`timescale 1ns / 1ps
package ftgs_pkg;

  localparam int XW     = 16;   // vertex coordinate, 12.4
  localparam int DXW    = 17;   // coordinate difference
  localparam int PRODW  = 34;   // product of two differences
  localparam int AREAW  = 35;   // signed doubled area, 8 fraction bits
  localparam int AW     = 33;   // attribute value, common signed form
  localparam int DW     = 34;   // attribute difference
  localparam int GPW    = 51;   // attribute difference times coordinate difference
  localparam int NW     = 56;   // gradient numerator, scaled by 16
  localparam int RW     = 48;   // result width
  localparam int WW     = 64;   // origin value working width
  localparam int NATTR  = 4;
  localparam int QDEPTH = 2;

  localparam logic [1:0] ATTR_DEPTH = 2'd0;
  localparam logic [1:0] ATTR_S     = 2'd1;
  localparam logic [1:0] ATTR_T     = 2'd2;
  localparam logic [1:0] ATTR_LIGHT = 2'd3;

  localparam logic [1:0] REG_KEEP_BACKFACES   = 2'd0;
  localparam logic [1:0] REG_LIGHT_ENABLE     = 2'd1;
  localparam logic [1:0] REG_SMALL_AREA_LIMIT = 2'd2;

  localparam logic [15:0] AREA_LIMIT_RESET = 16'd1280;

  localparam logic signed [WW-1:0] SAT_MAX = WW'({1'b0, {(RW-1){1'b1}}});
  localparam logic signed [WW-1:0] SAT_MIN = -SAT_MAX - WW'(1);

  typedef struct packed {
    logic signed [15:0] x_pos;
    logic signed [15:0] y_pos;
    logic [23:0]        depth_recip;
    logic signed [31:0] tex_s;
    logic signed [31:0] tex_t;
    logic [15:0]        light_level;
    logic               last_vertex;
  } in_word_t;

  typedef struct packed {
    logic [1:0]           attribute;
    logic signed [RW-1:0] step_x;
    logic signed [RW-1:0] step_y;
    logic signed [RW-1:0] value_at_origin;
    logic                 clamp_adjust;
    logic                 backfacing;
    logic                 tiny_triangle;
    logic                 saturated;
    logic                 last_of_triangle;
  } out_word_t;

  // One kept triangle, as handed from the front to the back.
  typedef struct packed {
    logic signed [XW-1:0]    x0;
    logic signed [XW-1:0]    y0;
    logic signed [DXW-1:0]   dx1;
    logic signed [DXW-1:0]   dy1;
    logic signed [DXW-1:0]   dx2;
    logic signed [DXW-1:0]   dy2;
    logic signed [AREAW-1:0] area;
    logic                    back;
    logic                    tiny;
    logic                    light_on;
    logic [NATTR-1:0][AW-1:0] a0;
    logic [NATTR-1:0][AW-1:0] a1;
    logic [NATTR-1:0][AW-1:0] a2;
  } job_t;

  typedef struct packed {
    logic signed [RW-1:0] val;
    logic                 clip;
  } sat_t;

  function automatic sat_t sat_rw(input logic signed [WW-1:0] v);
    sat_t r;
    if (v > SAT_MAX) begin
      r.val  = SAT_MAX[RW-1:0];
      r.clip = 1'b1;
    end else if (v < SAT_MIN) begin
      r.val  = SAT_MIN[RW-1:0];
      r.clip = 1'b1;
    end else begin
      r.val  = v[RW-1:0];
      r.clip = 1'b0;
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/ftgs_front.sv =====
`timescale 1ns / 1ps
module ftgs_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               vtx_valid,
  output logic               vtx_ready,
  input  ftgs_pkg::in_word_t vtx,
  output logic               job_push,
  input  logic               job_full,
  output ftgs_pkg::job_t     job
);

  typedef enum logic [1:0] {F_IDLE, F_MUL, F_PUSH} fstate_t;

  fstate_t            state;
  ftgs_pkg::in_word_t cur;
  ftgs_pkg::in_word_t anchor;
  ftgs_pkg::in_word_t prev;
  logic [1:0]         count;
  logic               keep_backfaces;
  logic               light_enable;
  logic [15:0]        small_area_limit;

  logic signed [ftgs_pkg::DXW-1:0]   dx1, dy1, dx2, dy2;
  logic signed [ftgs_pkg::DXW-1:0]   dx1_next, dy1_next, dx2_next, dy2_next;
  logic signed [ftgs_pkg::PRODW-1:0] m1, m2;
  logic signed [ftgs_pkg::AREAW-1:0] area, mag;
  logic                              keep, back, tiny, need, advance;

  assign vtx_ready = (state == F_IDLE);

  always_comb begin
    dx1_next = $signed({prev.x_pos[15], prev.x_pos}) - $signed({anchor.x_pos[15], anchor.x_pos});
    dy1_next = $signed({prev.y_pos[15], prev.y_pos}) - $signed({anchor.y_pos[15], anchor.y_pos});
    dx2_next = $signed({cur.x_pos[15], cur.x_pos}) - $signed({anchor.x_pos[15], anchor.x_pos});
    dy2_next = $signed({cur.y_pos[15], cur.y_pos}) - $signed({anchor.y_pos[15], anchor.y_pos});
  end

  always_comb begin
    area    = ftgs_pkg::AREAW'(m1) - ftgs_pkg::AREAW'(m2);
    back    = area < 0;
    keep    = (area > 0) || (back && keep_backfaces);
    mag     = back ? -area : area;
    tiny    = mag < $signed({1'b0, ftgs_pkg::AREAW'(small_area_limit)});
    need    = (count == 2'd2) && keep;
    advance = (state == F_PUSH) && (!need || !job_full);
  end

  assign job_push = (state == F_PUSH) && need && !job_full;

  always_comb begin
    job.x0       = anchor.x_pos;
    job.y0       = anchor.y_pos;
    job.dx1      = dx1;
    job.dy1      = dy1;
    job.dx2      = dx2;
    job.dy2      = dy2;
    job.area     = area;
    job.back     = back;
    job.tiny     = tiny;
    job.light_on = light_enable;
    job.a0[ftgs_pkg::ATTR_DEPTH] = {9'b0, anchor.depth_recip};
    job.a1[ftgs_pkg::ATTR_DEPTH] = {9'b0, prev.depth_recip};
    job.a2[ftgs_pkg::ATTR_DEPTH] = {9'b0, cur.depth_recip};
    job.a0[ftgs_pkg::ATTR_S]     = {anchor.tex_s[31], anchor.tex_s};
    job.a1[ftgs_pkg::ATTR_S]     = {prev.tex_s[31], prev.tex_s};
    job.a2[ftgs_pkg::ATTR_S]     = {cur.tex_s[31], cur.tex_s};
    job.a0[ftgs_pkg::ATTR_T]     = {anchor.tex_t[31], anchor.tex_t};
    job.a1[ftgs_pkg::ATTR_T]     = {prev.tex_t[31], prev.tex_t};
    job.a2[ftgs_pkg::ATTR_T]     = {cur.tex_t[31], cur.tex_t};
    job.a0[ftgs_pkg::ATTR_LIGHT] = {17'b0, anchor.light_level};
    job.a1[ftgs_pkg::ATTR_LIGHT] = {17'b0, prev.light_level};
    job.a2[ftgs_pkg::ATTR_LIGHT] = {17'b0, cur.light_level};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      keep_backfaces   <= 1'b0;
      light_enable     <= 1'b1;
      small_area_limit <= ftgs_pkg::AREA_LIMIT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ftgs_pkg::REG_KEEP_BACKFACES:   keep_backfaces   <= cfg_data[0];
        ftgs_pkg::REG_LIGHT_ENABLE:     light_enable     <= cfg_data[0];
        ftgs_pkg::REG_SMALL_AREA_LIMIT: small_area_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
      count <= 2'd0;
    end else begin
      unique case (state)
        F_IDLE: begin
          if (vtx_valid) begin
            cur   <= vtx;
            state <= F_MUL;
          end
        end
        F_MUL: begin
          dx1   <= dx1_next;
          dy1   <= dy1_next;
          dx2   <= dx2_next;
          dy2   <= dy2_next;
          m1    <= dx2_next * dy1_next;
          m2    <= dx1_next * dy2_next;
          state <= F_PUSH;
        end
        F_PUSH: begin
          if (advance) begin
            if (count == 2'd0) begin
              anchor <= cur;
            end else begin
              prev <= cur;
            end
            if (cur.last_vertex) begin
              count <= 2'd0;
            end else if (count == 2'd0) begin
              count <= 2'd1;
            end else begin
              count <= 2'd2;
            end
            state <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/core/ftgs_queue.sv =====
`timescale 1ns / 1ps
module ftgs_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  ftgs_pkg::job_t push_data,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output ftgs_pkg::job_t pop_data
);

  localparam int PW = (ftgs_pkg::QDEPTH > 1) ? $clog2(ftgs_pkg::QDEPTH) : 1;
  localparam int CW = $clog2(ftgs_pkg::QDEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(ftgs_pkg::QDEPTH - 1);

  ftgs_pkg::job_t mem [ftgs_pkg::QDEPTH];
  logic [PW-1:0]  wr_ptr, rd_ptr;
  logic [CW-1:0]  fill;

  assign full     = (fill == CW'(ftgs_pkg::QDEPTH));
  assign empty    = (fill == '0);
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        fill <= fill + CW'(1);
      end else if (pop && !push) begin
        fill <= fill - CW'(1);
      end
    end
  end

endmodule

// ===== rtl/core/ftgs_div.sv =====
`timescale 1ns / 1ps
module ftgs_div (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic signed [ftgs_pkg::NW-1:0]      num,
  input  logic signed [ftgs_pkg::AREAW-1:0]   den,
  output logic                                done,
  output logic signed [ftgs_pkg::NW-1:0]      quo
);

  localparam int NW = ftgs_pkg::NW;
  localparam int DV = ftgs_pkg::AREAW;
  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] nq;
  logic [DV-1:0] dmag;
  logic [DV:0]   rem, rem_sh, diff;
  logic [CW-1:0] cnt;
  logic          neg, busy, ge;

  // Restoring division on magnitudes, one quotient bit per cycle. The
  // numerator register shifts out dividend bits and takes quotient bits in.
  always_comb begin
    rem_sh = {rem[DV-1:0], nq[NW-1]};
    diff   = rem_sh - {1'b0, dmag};
    ge     = rem_sh >= {1'b0, dmag};
  end

  assign quo = neg ? -$signed(nq) : $signed(nq);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        nq   <= num[NW-1] ? NW'(-num) : NW'(num);
        dmag <= den[DV-1] ? DV'(-den) : DV'(den);
        neg  <= num[NW-1] ^ den[DV-1];
        rem  <= '0;
        cnt  <= CW'(NW);
        busy <= 1'b1;
      end else if (busy) begin
        rem <= ge ? diff : rem_sh;
        nq  <= {nq[NW-2:0], ge};
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== rtl/core/ftgs_back.sv =====
`timescale 1ns / 1ps
module ftgs_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                job_valid,
  input  ftgs_pkg::job_t      job,
  output logic                job_pop,
  output logic                res_valid,
  input  logic                res_ready,
  output ftgs_pkg::out_word_t res
);

  typedef enum logic [3:0] {
    B_IDLE, B_ATTR, B_MULX, B_DIVX, B_WAITX, B_DIVY, B_WAITY, B_MULV, B_SUM, B_OUT
  } bstate_t;

  bstate_t        state;
  ftgs_pkg::job_t cur;
  logic [1:0]     k, last_k;

  logic signed [ftgs_pkg::AW-1:0]  a0v, a0_sel, a1_sel, a2_sel;
  logic signed [ftgs_pkg::DW-1:0]  d1, d2;
  logic signed [ftgs_pkg::GPW-1:0] p1, p2;
  logic signed [ftgs_pkg::GPW:0]   pdiff;
  logic signed [ftgs_pkg::RW-1:0]  sx, sy, val;
  logic signed [ftgs_pkg::WW-1:0]  px, py, vsum;
  logic                            sat_any;

  logic                            div_start, div_done, res_free, res_load;
  logic signed [ftgs_pkg::NW-1:0]  div_num, div_quo;
  ftgs_pkg::sat_t                  qs, vs;

  always_comb begin
    a0_sel = $signed(cur.a0[k]);
    a1_sel = $signed(cur.a1[k]);
    a2_sel = $signed(cur.a2[k]);
    pdiff  = $signed({p1[ftgs_pkg::GPW-1], p1}) - $signed({p2[ftgs_pkg::GPW-1], p2});
    // The y numerator carries the opposite sign of the x numerator.
    if (state == B_DIVY) begin
      div_num = $signed({-pdiff, 4'b0000});
    end else begin
      div_num = $signed({pdiff, 4'b0000});
    end
    div_start = (state == B_DIVX) || (state == B_DIVY);
    qs        = ftgs_pkg::sat_rw(ftgs_pkg::WW'(div_quo));
    vsum      = ftgs_pkg::WW'(a0v) - ((px >>> 4) + (py >>> 4));
    vs        = ftgs_pkg::sat_rw(vsum);
    res_free  = !res_valid || res_ready;
    res_load  = (state == B_OUT) && res_free;
  end

  assign job_pop = (state == B_IDLE) && job_valid;

  ftgs_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (cur.area),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_load) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      unique case (state)
        B_IDLE: begin
          if (job_valid) begin
            cur    <= job;
            k      <= ftgs_pkg::ATTR_DEPTH;
            last_k <= job.light_on ? ftgs_pkg::ATTR_LIGHT : ftgs_pkg::ATTR_T;
            state  <= B_ATTR;
          end
        end
        B_ATTR: begin
          a0v     <= a0_sel;
          d1      <= ftgs_pkg::DW'(a1_sel) - ftgs_pkg::DW'(a0_sel);
          d2      <= ftgs_pkg::DW'(a2_sel) - ftgs_pkg::DW'(a0_sel);
          sat_any <= 1'b0;
          // A tiny triangle holds every attribute but depth constant.
          if (cur.tiny && (k != ftgs_pkg::ATTR_DEPTH)) begin
            sx    <= '0;
            sy    <= '0;
            val   <= ftgs_pkg::RW'(a0_sel);
            state <= B_OUT;
          end else begin
            state <= B_MULX;
          end
        end
        B_MULX: begin
          p1    <= d2 * cur.dy1;
          p2    <= d1 * cur.dy2;
          state <= B_DIVX;
        end
        B_DIVX: state <= B_WAITX;
        B_WAITX: begin
          if (div_done) begin
            sx      <= qs.val;
            sat_any <= sat_any | qs.clip;
            p1      <= d2 * cur.dx1;
            p2      <= d1 * cur.dx2;
            state   <= B_DIVY;
          end
        end
        B_DIVY: state <= B_WAITY;
        B_WAITY: begin
          if (div_done) begin
            sy      <= qs.val;
            sat_any <= sat_any | qs.clip;
            state   <= B_MULV;
          end
        end
        B_MULV: begin
          px    <= cur.x0 * sx;
          py    <= cur.y0 * sy;
          state <= B_SUM;
        end
        B_SUM: begin
          val     <= vs.val;
          sat_any <= sat_any | vs.clip;
          state   <= B_OUT;
        end
        B_OUT: begin
          if (res_free) begin
            res.attribute        <= k;
            res.step_x           <= sx;
            res.step_y           <= sy;
            res.value_at_origin  <= val;
            res.clamp_adjust     <= ((k == ftgs_pkg::ATTR_S) || (k == ftgs_pkg::ATTR_T))
                                    && ((sx < 0) || (sy < 0));
            res.backfacing       <= cur.back;
            res.tiny_triangle    <= cur.tiny;
            res.saturated        <= sat_any;
            res.last_of_triangle <= (k == last_k);
            if (k == last_k) begin
              state <= B_IDLE;
            end else begin
              k     <= k + 2'd1;
              state <= B_ATTR;
            end
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/core/fan_triangle_gradient_setup.sv =====
`timescale 1ns / 1ps
// Channel  | Direction | Handshake              | Word
// vertex   | in        | vtx_valid / vtx_ready  | vtx (ftgs_pkg::in_word_t)
// result   | out       | res_valid / res_ready  | res (ftgs_pkg::out_word_t)
// config   | in        | cfg_we                 | cfg_index, cfg_data
//
// The front takes a new vertex only after the last has passed its multiply and push
// states, and holds a vertex that closes a kept triangle while the queue is full.
// Each gradient attribute of a kept triangle takes two passes of the shared bit-serial
// divider in the back; an attribute held constant in a tiny triangle skips it.
// Synchronous reset clears the registers to their reset values and starts a new polygon.
// A stalled result word holds the back, and a full queue holds the front.
module fan_triangle_gradient_setup (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_data,
  input  logic                vtx_valid,
  output logic                vtx_ready,
  input  ftgs_pkg::in_word_t  vtx,
  output logic                res_valid,
  input  logic                res_ready,
  output ftgs_pkg::out_word_t res
);

  logic           push, full, pop, empty;
  ftgs_pkg::job_t push_job, pop_job;

  ftgs_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .vtx_valid (vtx_valid),
    .vtx_ready (vtx_ready),
    .vtx       (vtx),
    .job_push  (push),
    .job_full  (full),
    .job       (push_job)
  );

  ftgs_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_job),
    .full      (full),
    .pop       (pop),
    .empty     (empty),
    .pop_data  (pop_job)
  );

  ftgs_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (!empty),
    .job       (pop_job),
    .job_pop   (pop),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

endmodule

// ===== rtl/core/ftgs_checker.sv =====
`timescale 1ns / 1ps
module ftgs_checker (
  input logic                clk,
  input logic                rst,
  input logic                res_valid,
  input logic                res_ready,
  input ftgs_pkg::out_word_t res
);

  // A stalled result word holds its contents.
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res))
    else $error("result word changed while stalled");

  a_reset_quiet: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid right after reset");

  a_light_last: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res.attribute == ftgs_pkg::ATTR_LIGHT) |-> res.last_of_triangle)
    else $error("light word not marked last");

  a_clamp_scope: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res.tiny_triangle || (res.attribute == ftgs_pkg::ATTR_DEPTH)
                  || (res.attribute == ftgs_pkg::ATTR_LIGHT)) |-> !res.clamp_adjust)
    else $error("clamp adjust outside texture gradients");

  a_depth_first: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_ready && res.last_of_triangle ##1 res_valid |->
      (res.attribute == ftgs_pkg::ATTR_DEPTH))
    else $error("triangle does not start with depth");

endmodule

bind fan_triangle_gradient_setup ftgs_checker u_ftgs_checker (
  .clk       (clk),
  .rst       (rst),
  .res_valid (res_valid),
  .res_ready (res_ready),
  .res       (res)
);
